// ----- design/l3964_pkg.sv -----
`default_nettype none

package l3964_pkg;

    localparam int MAX_BYTES_DEF = 64;

    localparam int GAP_W = 16;
    localparam int LEN_W = 7;
    localparam logic [GAP_W-1:0] GAP_TIMEOUT_RST = 16'd220;

    // Line characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_DLE = 8'h10;

    // Request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Link modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    // Frame events
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_GOOD     = 3'd1;
    localparam logic [2:0] EV_MISMATCH = 3'd2;
    localparam logic [2:0] EV_OVERRUN  = 3'd3;
    localparam logic [2:0] EV_ESCAPE   = 3'd4;
    localparam logic [2:0] EV_TIMEOUT  = 3'd5;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic             send_ack;
        logic             data_valid;
        logic [7:0]       data_byte;
        logic [2:0]       frame_event;
        logic [LEN_W-1:0] telegram_length;
    } res_t;

    // Handshake between core and result register
    typedef struct packed {
        logic load;
        logic ready;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ----- design/l3964_if.sv -----
`default_nettype none

interface l3964_req_if
    import l3964_pkg::*;
();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface l3964_res_if
    import l3964_pkg::*;
();
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/link_3964r_receiver.sv -----
`default_nettype none

//  channel   dir  payload                                          beat taken when
//  req_ch    in   req_type, rx_byte                                valid & ready
//  res_ch    out  send_ack, data_valid, data_byte, frame_event,    valid & ready
//                 telegram_length
//  cfg       in   cfg_wdata (gap_timeout_ticks)                    cfg_we
//
//  A request beat updates the link state and lands in the
//  result register at the same edge, one result beat per request beat.
//  A new request is taken in every cycle while the result register is empty or
//  is being drained in that cycle.
//  Reset puts the link in idle with a gap timeout of 220 ticks.
//  A stalled result holds in the result register and stalls the request side.

module link_3964r_receiver
    import l3964_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [GAP_W-1:0] cfg_wdata,
    l3964_req_if.sink             req_ch,
    l3964_res_if.source           res_ch
);

    stage_ctl_t ctl;
    res_t       res;

    assign ctl.load   = req_ch.valid && ctl.ready;
    assign req_ch.ready = ctl.ready;

    l3964_rx_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .load      (ctl.load),
        .req       (req_ch.payload),
        .res       (res)
    );

    l3964_out_reg u_res_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .res    (res),
        .load   (ctl.load),
        .ready  (ctl.ready),
        .res_ch (res_ch)
    );

endmodule

`default_nettype wire

// ----- design/l3964_rx_core.sv -----
`default_nettype none

module l3964_rx_core
    import l3964_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [GAP_W-1:0] cfg_wdata,
    input  wire logic             load,
    input  wire req_t             req,
    output      res_t             res
);

    localparam int CNT_W = $clog2(MAX_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);

    logic [GAP_W-1:0] timeout_reg;
    logic [1:0]       mode_reg, mode_next;
    logic             esc_reg, esc_next;
    logic [7:0]       chk_reg, chk_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [GAP_W-1:0] gap_reg, gap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= GAP_TIMEOUT_RST;
            mode_reg    <= MODE_IDLE;
            esc_reg     <= 1'b0;
            chk_reg     <= '0;
            cnt_reg     <= '0;
            gap_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            chk_reg  <= chk_next;
            cnt_reg  <= cnt_next;
            gap_reg  <= gap_next;
        end
    end

    always_comb
    begin
        logic store;
        store     = 1'b0;
        res       = '0;
        mode_next = mode_reg;
        esc_next  = esc_reg;
        chk_next  = chk_reg;
        cnt_next  = cnt_reg;
        gap_next  = gap_reg;

        if (load)
        begin
            if (req.req_type == REQ_TICK)
            begin
                // saturate the gap counter
                if (gap_reg != '1)
                begin
                    gap_next = gap_reg + 1'b1;
                end
                if ((mode_reg == MODE_DATA || mode_reg == MODE_CHECK) &&
                    gap_next > timeout_reg)
                begin
                    res.frame_event = EV_TIMEOUT;
                    mode_next       = MODE_IDLE;
                    esc_next        = 1'b0;
                end
            end
            else
            begin
                gap_next = '0;
                unique case (mode_reg)
                    MODE_DATA:
                    begin
                        if (cnt_reg >= CNT_MAX)
                        begin
                            res.frame_event = EV_OVERRUN;
                            mode_next       = MODE_IDLE;
                            esc_next        = 1'b0;
                        end
                        else
                        begin
                            store    = 1'b1;
                            chk_next = chk_reg ^ req.rx_byte;
                            if (req.rx_byte == CH_DLE)
                            begin
                                // first DLE is held back, second one is data
                                esc_next = !esc_reg;
                                store    = esc_reg;
                            end
                            else if (req.rx_byte == CH_ETX && esc_reg)
                            begin
                                esc_next  = 1'b0;
                                mode_next = MODE_CHECK;
                                store     = 1'b0;
                            end
                            else if (esc_reg)
                            begin
                                res.frame_event = EV_ESCAPE;
                                mode_next       = MODE_IDLE;
                                esc_next        = 1'b0;
                                store           = 1'b0;
                            end
                            if (store)
                            begin
                                res.data_valid = 1'b1;
                                res.data_byte  = req.rx_byte;
                                cnt_next       = cnt_reg + 1'b1;
                            end
                        end
                    end
                    MODE_CHECK:
                    begin
                        if (req.rx_byte == chk_reg)
                        begin
                            res.send_ack    = 1'b1;
                            res.frame_event = EV_GOOD;
                        end
                        else
                        begin
                            res.frame_event = EV_MISMATCH;
                        end
                        mode_next = MODE_IDLE;
                        esc_next  = 1'b0;
                    end
                    default:
                    begin
                        if (req.rx_byte == CH_STX)
                        begin
                            res.send_ack = 1'b1;
                            mode_next    = MODE_DATA;
                            esc_next     = 1'b0;
                            chk_next     = '0;
                            cnt_next     = '0;
                        end
                    end
                endcase
            end
        end
        res.telegram_length = LEN_W'(cnt_next);
    end

    a_idle_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE || mode_reg == MODE_CHECK) |-> !esc_reg)
        else $error("escape pending outside the data phase");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("byte count beyond buffer size");

    a_byte_clears_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (load && req.req_type == REQ_BYTE) |=> gap_reg == '0)
        else $error("gap counter not cleared by a received byte");

    a_data_only_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res.data_valid) |-> mode_reg == MODE_DATA)
        else $error("data byte emitted outside the data phase");

endmodule

`default_nettype wire

// ----- design/l3964_out_reg.sv -----
`default_nettype none

module l3964_out_reg
    import l3964_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire res_t   res,
    input  wire logic   load,
    output      logic   ready,
    l3964_res_if.source res_ch
);

    logic valid_reg;
    res_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                data_reg  <= res;
            end
            else if (res_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // take a new beat when empty or when the held one drains this cycle
    assign ready          = !valid_reg || res_ch.ready;
    assign res_ch.valid   = valid_reg;
    assign res_ch.payload = data_reg;

    a_load_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ready)
        else $error("result register loaded while full");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded beat not presented");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !res_ch.ready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled result beat changed or dropped");

endmodule

`default_nettype wire
